@@ design/ldf_pkg.sv @@
// ldf_pkg: shared constants, codes and types of the line derivative filter
// used by ldf_round_div and line_derivative_filter; depends on nothing else

package ldf_pkg;

    // default widths of the sample path
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF   = 8;

    // window geometry: newest sample plus six taps held in the cell chain
    localparam int MAX_TAPS = 7;
    localparam int POS_BITS = 3;
    localparam logic [POS_BITS-1:0] POS_MAX = 3'd7;

    // result word
    localparam int DERIV_BITS  = 25;
    localparam int M_DATA_BITS = ((DERIV_BITS + 7) / 8) * 8;
    localparam logic [DERIV_BITS-1:0] DERIV_MAX = {1'b0, {(DERIV_BITS - 1){1'b1}}};
    localparam logic [DERIV_BITS-1:0] DERIV_MIN = {1'b1, {(DERIV_BITS - 1){1'b0}}};

    // results caused by one sample: one value plus up to three border zeros
    localparam int MAX_RESULTS = 4;
    localparam int CNT_BITS    = 3;

    // method register
    localparam int METHOD_BITS = 3;
    localparam logic [METHOD_BITS-1:0] METH_CENTRAL = 3'd0;
    localparam logic [METHOD_BITS-1:0] METH_NEXT    = 3'd1;
    localparam logic [METHOD_BITS-1:0] METH_SG5     = 3'd2;
    localparam logic [METHOD_BITS-1:0] METH_SG7     = 3'd3;

    // divisor selection for the rounding divider
    localparam logic [1:0] DIV_ONE = 2'd0;
    localparam logic [1:0] DIV_TWO = 2'd1;
    localparam logic [1:0] DIV_TEN = 2'd2;
    localparam logic [1:0] DIV_28  = 2'd3;

    // bookkeeping that travels with each sample through the pipeline
    typedef struct packed {
        logic [CNT_BITS-1:0] cnt;
        logic                last;
    } res_meta_t;

endpackage

@@ design/ldf_tap_cell.sv @@
// ldf_tap_cell: one cell of the sample window chain
// holds one past sample and hands it to the next cell on every shift; no dependencies

module ldf_tap_cell #(
    parameter int WIDTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             shift_en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] q_reg;

    // take the neighbor's sample on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
        end
        else if (shift_en)
        begin
            q_reg <= d;
        end
    end

    assign q = q_reg;

endmodule

@@ design/ldf_round_div.sv @@
// ldf_round_div: scales a filter sum to fixed point and divides by 1, 2, 10 or 28,
// rounding to nearest with ties away from zero; two stages; uses ldf_pkg

module ldf_round_div #(
    parameter int SAMPLE_BITS = ldf_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = ldf_pkg::FRAC_BITS_DEF,
    localparam int SUMW = SAMPLE_BITS + 4,
    localparam int MW   = SAMPLE_BITS + FRAC_BITS + 4
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [SUMW-1:0]  in_sum,
    input  logic [1:0]              in_div,
    input  ldf_pkg::res_meta_t      in_meta,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [MW-1:0]           out_q,
    output logic                    out_neg,
    output ldf_pkg::res_meta_t      out_meta
);

    // reciprocal constants: floor(x/d) == (x*ceil(2^K/d)) >> K for x < 2^MW, d <= 7
    localparam int K  = MW + 3;
    localparam int PW = MW + K - 1;
    localparam logic [K:0]   POW_K = (K + 1)'(1) << K;
    localparam logic [K-2:0] RECIP5 = (K - 1)'((POW_K + (K + 1)'(4)) / (K + 1)'(5));
    localparam logic [K-2:0] RECIP7 = (K - 1)'((POW_K + (K + 1)'(6)) / (K + 1)'(7));

    logic                 a_valid_reg;
    logic [MW-1:0]        a_pre_reg;
    logic                 a_neg_reg;
    logic [1:0]           a_div_reg;
    ldf_pkg::res_meta_t   a_meta_reg;

    logic                 b_valid_reg;
    logic [MW-1:0]        b_q_reg;
    logic                 b_neg_reg;
    ldf_pkg::res_meta_t   b_meta_reg;

    logic                 a_ready;
    logic                 b_ready;
    logic signed [SUMW-1:0] abs_s;
    logic [MW-1:0]        mag;
    logic [MW-1:0]        pre_next;
    logic [K-2:0]         recip;
    logic [PW-1:0]        prod;
    logic [MW-1:0]        q_next;

    // stage handshake
    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    // stage a: magnitude, scale, add half divisor, pre-shift for the even factors
    always_comb
    begin
        abs_s = in_sum[SUMW-1] ? -in_sum : in_sum;
        mag   = MW'(abs_s[SUMW-2:0]) << FRAC_BITS;
        case (in_div)
            ldf_pkg::DIV_TWO: pre_next = (mag + MW'(1)) >> 1;
            ldf_pkg::DIV_TEN: pre_next = (mag + MW'(5)) >> 1;
            ldf_pkg::DIV_28:  pre_next = (mag + MW'(14)) >> 2;
            default:          pre_next = mag;
        endcase
    end

    // stage b: reciprocal multiply for the odd factors 5 and 7
    always_comb
    begin
        recip = (a_div_reg == ldf_pkg::DIV_28) ? RECIP7 : RECIP5;
        prod  = PW'(a_pre_reg) * PW'(recip);
        if (a_div_reg == ldf_pkg::DIV_TEN || a_div_reg == ldf_pkg::DIV_28)
        begin
            q_next = MW'(prod >> K);
        end
        else
        begin
            q_next = a_pre_reg;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= (in_valid && a_ready) || (a_valid_reg && !b_ready);
            b_valid_reg <= (a_valid_reg && b_ready) || (b_valid_reg && !out_ready);
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_valid && a_ready)
        begin
            a_pre_reg  <= pre_next;
            a_neg_reg  <= in_sum[SUMW-1];
            a_div_reg  <= in_div;
            a_meta_reg <= in_meta;
        end
        if (a_valid_reg && b_ready)
        begin
            b_q_reg    <= q_next;
            b_neg_reg  <= a_neg_reg;
            b_meta_reg <= a_meta_reg;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_q     = b_q_reg;
    assign out_neg   = b_neg_reg;
    assign out_meta  = b_meta_reg;

endmodule

@@ design/line_derivative_filter.sv @@
// line_derivative_filter: top level of the streaming line derivative filter
// uses ldf_pkg, ldf_tap_cell (window chain) and ldf_round_div (scaling divider)
//
// Usage: samples of one image line enter on the s_ group, one word per sample,
// s_tdata holding the signed sample and s_tlast marking the final sample of the
// line. Derivatives leave on the m_ group in position order, m_tdata holding the
// signed fixed-point value and m_tlast marking the final result of the line.
// cfg_we/cfg_wdata write the method register (0 central difference, 1 difference
// to next, 2 five-tap and 3 seven-tap Savitzky-Golay, other codes pass through);
// write it only between lines while the block is empty.
// A sample's result word passes stage 1, the two divider stages and the output
// register before it appears on m_. Samples are taken one per cycle while
// s_tready is high. A sample carrying s_tlast produces up to four words (its
// result plus the right-border zeros); the output register emits them one per
// cycle while m_tready is high, and meanwhile s_tready can fall. The rate is set
// by the output register, which loads one sample's results while handing out
// the last word of the one before. Reset clears the window cells, the line
// position, the method register and all pipeline valid bits. When the receiver
// stalls, the four-stage pipeline fills and s_tready falls; no word is lost or repeated.

module line_derivative_filter #(
    parameter int SAMPLE_BITS = ldf_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = ldf_pkg::FRAC_BITS_DEF,
    localparam int S_DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // sample stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [S_DATA_BITS-1:0]               s_tdata,   // sample
    input  logic                                 s_tlast,   // last_in_line
    // derivative stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [ldf_pkg::M_DATA_BITS-1:0]      m_tdata,   // derivative
    output logic                                 m_tlast,   // last_of_line
    // method register
    input  logic                                 cfg_we,
    input  logic [ldf_pkg::METHOD_BITS-1:0]      cfg_wdata
);

    localparam int SW   = SAMPLE_BITS;
    localparam int SUMW = SAMPLE_BITS + 4;
    localparam int MW   = SAMPLE_BITS + FRAC_BITS + 4;
    localparam int DB   = ldf_pkg::DERIV_BITS;
    localparam int CW   = ((MW > DB) ? MW : DB) + 1;
    localparam int NCELLS = ldf_pkg::MAX_TAPS - 1;

    logic [ldf_pkg::METHOD_BITS-1:0] method_reg;
    logic [ldf_pkg::POS_BITS-1:0]    pos_reg;

    logic                  s_acc;
    logic signed [SW-1:0]  h [0:ldf_pkg::MAX_TAPS-1];
    logic [SW-1:0]         tap [0:NCELLS-1];

    logic [1:0]                   lh;
    logic [1:0]                   rh;
    logic [1:0]                   div_c;
    logic signed [SUMW-1:0]       sum_c;
    logic                         emit;
    logic                         full;
    logic [ldf_pkg::CNT_BITS-1:0] cnt_c;

    logic                   s1_valid_reg;
    logic signed [SUMW-1:0] s1_sum_reg;
    logic [1:0]             s1_div_reg;
    ldf_pkg::res_meta_t     s1_meta_reg;
    ldf_pkg::res_meta_t     s1_meta_next;
    logic                   s1_ready;

    logic                   rd_in_ready;
    logic                   rd_q_valid;
    logic [MW-1:0]          rd_q;
    logic                   rd_neg;
    ldf_pkg::res_meta_t     rd_meta;

    logic [ldf_pkg::CNT_BITS-1:0] cnt_reg;
    logic                         first_reg;
    logic                         last_reg;
    logic [DB-1:0]                val_reg;
    logic [DB-1:0]                val_next;
    logic [CW-1:0]                cq;
    logic                         out_free;
    logic                         m_acc;
    logic [DB-1:0]                deriv;

    function automatic logic signed [SUMW-1:0] diff(input logic signed [SW-1:0] a,
                                                    input logic signed [SW-1:0] b);
        diff = SUMW'(a) - SUMW'(b);
    endfunction

    assign s_acc    = s_tvalid && s_tready;
    assign s_tready = s1_ready;

    // method register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            method_reg <= ldf_pkg::METH_CENTRAL;
        end
        else if (cfg_we)
        begin
            method_reg <= cfg_wdata;
        end
    end

    // window: newest sample plus the chain of cells
    assign h[0] = $signed(s_tdata[SW-1:0]);

    genvar gi;
    generate
        for (gi = 0; gi < NCELLS; gi++)
        begin : g_cell
            ldf_tap_cell #(
                .WIDTH (SW)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (s_acc),
                .d        ((gi == 0) ? s_tdata[SW-1:0] : tap[(gi == 0) ? 0 : gi - 1]),
                .q        (tap[gi])
            );
            assign h[gi + 1] = $signed(tap[gi]);
        end
    endgenerate

    // filter sum, half windows and divisor for the current method
    always_comb
    begin
        case (method_reg)
            ldf_pkg::METH_CENTRAL:
            begin
                lh    = 2'd1;
                rh    = 2'd1;
                div_c = ldf_pkg::DIV_TWO;
                sum_c = diff(h[0], h[2]);
            end
            ldf_pkg::METH_NEXT:
            begin
                lh    = 2'd0;
                rh    = 2'd1;
                div_c = ldf_pkg::DIV_ONE;
                sum_c = diff(h[0], h[1]);
            end
            ldf_pkg::METH_SG5:
            begin
                lh    = 2'd2;
                rh    = 2'd2;
                div_c = ldf_pkg::DIV_TEN;
                sum_c = (diff(h[0], h[4]) <<< 1) + diff(h[1], h[3]);
            end
            ldf_pkg::METH_SG7:
            begin
                lh    = 2'd3;
                rh    = 2'd3;
                div_c = ldf_pkg::DIV_28;
                sum_c = (diff(h[0], h[6]) <<< 1) + diff(h[0], h[6])
                      + (diff(h[1], h[5]) <<< 1) + diff(h[2], h[4]);
            end
            default:
            begin
                lh    = 2'd0;
                rh    = 2'd0;
                div_c = ldf_pkg::DIV_ONE;
                sum_c = SUMW'(h[0]);
            end
        endcase
    end

    // result count: own value once the right neighbors are in, plus border zeros
    always_comb
    begin
        emit = (pos_reg >= ldf_pkg::POS_BITS'(rh));
        full = (pos_reg >= (ldf_pkg::POS_BITS'(lh) + ldf_pkg::POS_BITS'(rh)));
        if (emit)
        begin
            cnt_c = ldf_pkg::CNT_BITS'(1) + (s_tlast ? ldf_pkg::CNT_BITS'(rh) : '0);
        end
        else
        begin
            cnt_c = s_tlast ? ldf_pkg::CNT_BITS'(pos_reg + ldf_pkg::POS_BITS'(1)) : '0;
        end
        s1_meta_next.cnt  = cnt_c;
        s1_meta_next.last = s_tlast;
    end

    // line position, saturating
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (s_acc)
        begin
            if (s_tlast)
            begin
                pos_reg <= '0;
            end
            else if (pos_reg != ldf_pkg::POS_MAX)
            begin
                pos_reg <= pos_reg + ldf_pkg::POS_BITS'(1);
            end
        end
    end

    // stage 1: registered sum
    assign s1_ready = !s1_valid_reg || rd_in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s_acc || (s1_valid_reg && !rd_in_ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            s1_sum_reg  <= full ? sum_c : '0;
            s1_div_reg  <= div_c;
            s1_meta_reg <= s1_meta_next;
        end
    end

    // stages 2 and 3: scaling and rounding divide
    ldf_round_div #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid_reg),
        .in_ready  (rd_in_ready),
        .in_sum    (s1_sum_reg),
        .in_div    (s1_div_reg),
        .in_meta   (s1_meta_reg),
        .out_valid (rd_q_valid),
        .out_ready (out_free),
        .out_q     (rd_q),
        .out_neg   (rd_neg),
        .out_meta  (rd_meta)
    );

    // sign and saturate into the result width
    always_comb
    begin
        cq = CW'(rd_q);
        if (!rd_neg)
        begin
            val_next = (cq > CW'(ldf_pkg::DERIV_MAX)) ? ldf_pkg::DERIV_MAX : DB'(cq);
        end
        else
        begin
            val_next = (cq > CW'(ldf_pkg::DERIV_MIN)) ? ldf_pkg::DERIV_MIN
                                                     : DB'(CW'(0) - cq);
        end
    end

    // output register: one value word followed by border zero words
    assign m_acc    = m_tvalid && m_tready;
    assign out_free = (cnt_reg == '0) || ((cnt_reg == ldf_pkg::CNT_BITS'(1)) && m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            first_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else if (rd_q_valid && out_free)
        begin
            cnt_reg   <= rd_meta.cnt;
            first_reg <= 1'b1;
            last_reg  <= rd_meta.last;
        end
        else if (m_acc)
        begin
            cnt_reg   <= cnt_reg - ldf_pkg::CNT_BITS'(1);
            first_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_q_valid && out_free)
        begin
            val_reg <= val_next;
        end
    end

    assign deriv    = first_reg ? val_reg : '0;
    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = ldf_pkg::M_DATA_BITS'(deriv);
    assign m_tlast  = last_reg && (cnt_reg == ldf_pkg::CNT_BITS'(1));

`ifndef SYNTHESIS
    // never more words pending than one sample can cause
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= ldf_pkg::CNT_BITS'(ldf_pkg::MAX_RESULTS))
        else $error("output word count out of range");

    // a line end restarts the position
    a_pos_restart: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && s_tlast |=> pos_reg == '0)
        else $error("position not cleared after line end");

    // only the first word of a sample carries a value, the rest are border zeros
    a_zero_tail: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !first_reg |-> m_tdata == '0)
        else $error("border word is not zero");

    // a divider result waits while the output register is busy
    a_div_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rd_q_valid && !out_free |=> rd_q_valid)
        else $error("divider result dropped");
`endif

endmodule
